FILE: rtl/apt_pkg.sv
// apt_pkg: widths, register map and rounding helpers for the affine point transform.
// No dependencies; used by the channel interfaces and by affine_point_transform_core.
package apt_pkg;

	// coordinate and coefficient formats
	localparam int COORD_W = 16;
	localparam int FRAC_W  = 16;
	localparam int COEF_W  = FRAC_W + 8;

	// datapath widths
	localparam int PROD_W = COORD_W + COEF_W;
	localparam int TERM_W = PROD_W - FRAC_W + 1;
	localparam int SUM_W  = TERM_W + 2;

	// configuration port
	localparam int NUM_REGS = 6;
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam int ADDR_W = REG_IDX_W + 2;
	localparam int DATA_W = 32;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [TERM_W-1:0]  term_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	// register indexes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_COEF_XX  = REG_IDX_W'(0),
		REG_COEF_XY  = REG_IDX_W'(1),
		REG_COEF_YX  = REG_IDX_W'(2),
		REG_COEF_YY  = REG_IDX_W'(3),
		REG_OFFSET_X = REG_IDX_W'(4),
		REG_OFFSET_Y = REG_IDX_W'(5)
	} reg_idx_t;

	localparam coef_t COEF_ONE  = coef_t'(1) <<< FRAC_W;
	localparam coef_t COEF_ZERO = '0;

	// saturation bounds in sum width
	localparam sum_t SAT_MAX = sum_t'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
	localparam sum_t SAT_MIN = sum_t'(-(64'sd1 <<< (COORD_W - 1)));

	// round half up: floor(p / 2^FRAC_W + 1/2)
	function automatic term_t round_term(input prod_t p);
		logic signed [PROD_W:0] t;
		t = {p[PROD_W-1], p} + (PROD_W+1)'(64'd1 << (FRAC_W - 1));
		return t[PROD_W:FRAC_W];
	endfunction

endpackage

FILE: rtl/apt_vertex_if.sv
// apt_vertex_if: valid/ready channel carrying one input vertex per beat.
// Depends on apt_pkg for the coordinate type.
interface apt_vertex_if;
	logic           valid;
	logic           ready;
	apt_pkg::coord_t x_in;
	apt_pkg::coord_t y_in;

	modport source (output valid, output x_in, output y_in, input ready);
	modport sink   (input valid, input x_in, input y_in, output ready);
endinterface

FILE: rtl/apt_result_if.sv
// apt_result_if: valid/ready channel carrying one transformed point per beat.
// Depends on apt_pkg for the coordinate type.
interface apt_result_if;
	logic           valid;
	logic           ready;
	apt_pkg::coord_t x_out;
	apt_pkg::coord_t y_out;
	logic           clipped;

	modport source (output valid, output x_out, output y_out, output clipped, input ready);
	modport sink   (input valid, input x_out, input y_out, input clipped, output ready);
endinterface

FILE: rtl/affine_point_transform_core.sv
// affine_point_transform_core: five-stage pipelined 2D affine transform with APB registers.
// Depends on apt_pkg, apt_vertex_if and apt_result_if.
//
//  channel   dir  handshake     payload
//  vertex    in   valid/ready   x_in, y_in (signed 16)
//  result    out  valid/ready   x_out, y_out (signed 16), clipped
//  apb       in   psel/penable  paddr[4:0], pwdata/prdata 32, pready tied high
//
// Result valid rises when the beat reaches register s5 through s1 to s4; one vertex per cycle
// is sustained while result.ready is high, as every stage then takes a new beat each cycle.
// arst_n clears all valid bits and loads the identity matrix with zero offset.
// A stage advances when its successor is empty or advancing, so result.ready low
// holds the pipe and fills its bubbles without dropping or repeating a beat.
module affine_point_transform_core (
	input  logic                         clk,
	input  logic                         arst_n,
	apt_vertex_if.sink                   vertex,
	apt_result_if.source                 result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [apt_pkg::ADDR_W-1:0]   paddr,
	input  logic [apt_pkg::DATA_W-1:0]   pwdata,
	output logic [apt_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	apt_pkg::coef_t cfg_q [apt_pkg::NUM_REGS];

	logic [apt_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          reg_hit;
	logic                          cfg_wr;

	// stage registers
	logic            v_s1, v_s2, v_s3, v_s4, v_s5;
	apt_pkg::coord_t x_s1, y_s1;
	apt_pkg::prod_t  pxx_s2, pyx_s2, pxy_s2, pyy_s2;
	apt_pkg::term_t  txx_s3, tyx_s3, txy_s3, tyy_s3, tox_s3, toy_s3;
	apt_pkg::sum_t   sx_s4, sy_s4;
	apt_pkg::coord_t xo_s5, yo_s5;
	logic            clip_s5;

	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;
	logic sat_x_hi, sat_x_lo, sat_y_hi, sat_y_lo;

	// register file access
	assign pready  = 1'b1;
	assign reg_idx = paddr[apt_pkg::ADDR_W-1:2];
	assign reg_hit = (reg_idx < apt_pkg::REG_IDX_W'(apt_pkg::NUM_REGS));
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;

	always_comb begin
		prdata = '0;
		if (reg_hit) begin
			prdata = apt_pkg::DATA_W'(cfg_q[reg_idx]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[apt_pkg::REG_COEF_XX]  <= apt_pkg::COEF_ONE;
			cfg_q[apt_pkg::REG_COEF_XY]  <= apt_pkg::COEF_ZERO;
			cfg_q[apt_pkg::REG_COEF_YX]  <= apt_pkg::COEF_ZERO;
			cfg_q[apt_pkg::REG_COEF_YY]  <= apt_pkg::COEF_ONE;
			cfg_q[apt_pkg::REG_OFFSET_X] <= apt_pkg::COEF_ZERO;
			cfg_q[apt_pkg::REG_OFFSET_Y] <= apt_pkg::COEF_ZERO;
		end else if (cfg_wr) begin
			cfg_q[reg_idx] <= pwdata[apt_pkg::COEF_W-1:0];
		end
	end

	// flow control: a stage moves when the next one is empty or moving
	assign adv_s5 = !v_s5 || result.ready;
	assign adv_s4 = !v_s4 || adv_s5;
	assign adv_s3 = !v_s3 || adv_s4;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign vertex.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= vertex.valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
		end
	end

	// s1: capture vertex
	always_ff @(posedge clk) begin
		if (adv_s1 && vertex.valid) begin
			x_s1 <= vertex.x_in;
			y_s1 <= vertex.y_in;
		end
	end

	// s2: four products
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			pxx_s2 <= apt_pkg::prod_t'(x_s1) * apt_pkg::prod_t'(cfg_q[apt_pkg::REG_COEF_XX]);
			pyx_s2 <= apt_pkg::prod_t'(y_s1) * apt_pkg::prod_t'(cfg_q[apt_pkg::REG_COEF_YX]);
			pxy_s2 <= apt_pkg::prod_t'(x_s1) * apt_pkg::prod_t'(cfg_q[apt_pkg::REG_COEF_XY]);
			pyy_s2 <= apt_pkg::prod_t'(y_s1) * apt_pkg::prod_t'(cfg_q[apt_pkg::REG_COEF_YY]);
		end
	end

	// s3: round each term half up; offsets rounded alongside
	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			txx_s3 <= apt_pkg::round_term(pxx_s2);
			tyx_s3 <= apt_pkg::round_term(pyx_s2);
			txy_s3 <= apt_pkg::round_term(pxy_s2);
			tyy_s3 <= apt_pkg::round_term(pyy_s2);
			tox_s3 <= apt_pkg::round_term(apt_pkg::prod_t'(cfg_q[apt_pkg::REG_OFFSET_X]));
			toy_s3 <= apt_pkg::round_term(apt_pkg::prod_t'(cfg_q[apt_pkg::REG_OFFSET_Y]));
		end
	end

	// s4: exact sums
	always_ff @(posedge clk) begin
		if (adv_s4 && v_s3) begin
			sx_s4 <= apt_pkg::sum_t'(txx_s3) + apt_pkg::sum_t'(tyx_s3) + apt_pkg::sum_t'(tox_s3);
			sy_s4 <= apt_pkg::sum_t'(txy_s3) + apt_pkg::sum_t'(tyy_s3) + apt_pkg::sum_t'(toy_s3);
		end
	end

	// s5: saturate into the output register
	assign sat_x_hi = (sx_s4 > apt_pkg::SAT_MAX);
	assign sat_x_lo = (sx_s4 < apt_pkg::SAT_MIN);
	assign sat_y_hi = (sy_s4 > apt_pkg::SAT_MAX);
	assign sat_y_lo = (sy_s4 < apt_pkg::SAT_MIN);

	always_ff @(posedge clk) begin
		if (adv_s5 && v_s4) begin
			xo_s5   <= sat_x_hi ? apt_pkg::coord_t'(apt_pkg::SAT_MAX) :
			           sat_x_lo ? apt_pkg::coord_t'(apt_pkg::SAT_MIN) :
			           sx_s4[apt_pkg::COORD_W-1:0];
			yo_s5   <= sat_y_hi ? apt_pkg::coord_t'(apt_pkg::SAT_MAX) :
			           sat_y_lo ? apt_pkg::coord_t'(apt_pkg::SAT_MIN) :
			           sy_s4[apt_pkg::COORD_W-1:0];
			clip_s5 <= sat_x_hi || sat_x_lo || sat_y_hi || sat_y_lo;
		end
	end

	assign result.valid   = v_s5;
	assign result.x_out   = xo_s5;
	assign result.y_out   = yo_s5;
	assign result.clipped = clip_s5;

endmodule

FILE: bench/tb_affine_point_transform_core.sv
// tb_affine_point_transform_core: self-checking bench for the affine point transform.
// Depends on apt_pkg, apt_vertex_if, apt_result_if and affine_point_transform_core.
// Streams vertices under several matrix settings and checks each transformed point.
module tb_affine_point_transform_core;
	import apt_pkg::*;

	localparam int CLK_HALF = 6;
	localparam int RESET_CYCLES = 6;
	localparam int PIPE_LATENCY = 5;
	localparam int NUM_SETTINGS = 8;
	localparam int VERTS_PER_SETTING = 250;
	localparam int TIMEOUT = 4_000_000;
	// first index past the register map, must be ignored on write
	localparam int unsigned UNMAPPED_IDX = NUM_REGS;

	localparam coef_t COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam coef_t COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
	localparam coef_t COEF_HALF = coef_t'(1) <<< (FRAC_W - 1);
	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct {
		coord_t x;
		coord_t y;
	} vertex_t;

	typedef struct {
		coord_t x;
		coord_t y;
		logic   clipped;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// bench-side drivers, all known from time zero
	logic               vtx_valid = 1'b0;
	coord_t             vtx_x = '0;
	coord_t             vtx_y = '0;
	logic               res_ready = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	apt_vertex_if vertex_ch ();
	apt_result_if result_ch ();

	assign vertex_ch.valid = vtx_valid;
	assign vertex_ch.x_in  = vtx_x;
	assign vertex_ch.y_in  = vtx_y;
	assign result_ch.ready = res_ready;

	affine_point_transform_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.vertex  (vertex_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow copy of the matrix registers
	coef_t coef_shadow [NUM_REGS];

	vertex_t pending_verts [$];
	point_t  expected_pts [$];

	int unsigned send_idle_pct = 20;
	int unsigned recv_idle_pct = 61;
	int unsigned mismatch_cnt = 0;
	int unsigned vertex_cnt = 0;
	int unsigned clipped_cnt = 0;
	int unsigned setting_cnt = 0;

	// floor(p / 2^FRAC_W + 1/2), arithmetic shift floors negatives
	function automatic longint round_half_up(input longint p);
		return (p + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
	endfunction

	function automatic point_t transform_vertex(input coord_t x, input coord_t y);
		longint sx;
		longint sy;
		longint hi;
		longint lo;
		point_t pt;
		hi = (longint'(1) <<< (COORD_W - 1)) - 1;
		lo = -hi - 1;
		sx = round_half_up(longint'(x) * longint'(coef_shadow[REG_COEF_XX]))
			+ round_half_up(longint'(y) * longint'(coef_shadow[REG_COEF_YX]))
			+ round_half_up(longint'(coef_shadow[REG_OFFSET_X]));
		sy = round_half_up(longint'(x) * longint'(coef_shadow[REG_COEF_XY]))
			+ round_half_up(longint'(y) * longint'(coef_shadow[REG_COEF_YY]))
			+ round_half_up(longint'(coef_shadow[REG_OFFSET_Y]));
		pt.clipped = (sx > hi) || (sx < lo) || (sy > hi) || (sy < lo);
		if (sx > hi) sx = hi;
		if (sx < lo) sx = lo;
		if (sy > hi) sy = hi;
		if (sy < lo) sy = lo;
		pt.x = coord_t'(sx);
		pt.y = coord_t'(sy);
		return pt;
	endfunction

	function automatic coef_t rand_coef();
		case ($urandom_range(3))
			0: return coef_t'($urandom());
			// within about +-2.0
			1: return coef_t'(int'($urandom_range(4 * 65536)) - 2 * 65536);
			// multiples of one half, so ties are common
			2: return coef_t'((int'($urandom_range(32)) - 16) <<< (FRAC_W - 1));
			default: begin
				case ($urandom_range(4))
					0: return COEF_MAX;
					1: return COEF_MIN;
					2: return COEF_ONE;
					3: return -COEF_ONE;
					default: return COEF_ZERO;
				endcase
			end
		endcase
	endfunction

	function automatic coord_t rand_coord();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 50)
			return coord_t'($urandom());
		if (pick < 85)
			return coord_t'(int'($urandom_range(1024)) - 512);
		case ($urandom_range(4))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return coord_t'(1);
			3: return coord_t'(-1);
			default: return coord_t'(0);
		endcase
	endfunction

	task automatic queue_vertex(input coord_t x, input coord_t y);
		vertex_t v;
		v.x = x;
		v.y = y;
		pending_verts.push_back(v);
	endtask

	// APB write: setup, then access until pready; shadow follows the write edge
	task automatic reg_write(input int unsigned idx, input logic [DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(idx * 4);
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx < NUM_REGS)
			coef_shadow[idx] = coef_t'(data[COEF_W-1:0]);
	endtask

	// upper bits are either sign copies or junk; the block must drop them
	task automatic set_coef(input int unsigned idx, input coef_t value);
		logic [DATA_W-COEF_W-1:0] upper;
		upper = $urandom_range(1) ? (DATA_W-COEF_W)'($urandom())
			: {(DATA_W-COEF_W){value[COEF_W-1]}};
		reg_write(idx, {upper, value});
	endtask

	// hold off until the pipe is empty, then let it settle
	task automatic drain_pipe();
		while (pending_verts.size() != 0 || vtx_valid || expected_pts.size() != 0)
			@(negedge clk);
		repeat (2 * PIPE_LATENCY) @(posedge clk);
	endtask

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#TIMEOUT;
		$error("timeout with %0d results outstanding", expected_pts.size());
		$display("end of test: mismatches");
		$finish;
	end

	// vertex driver: records the beat's expected point when it is accepted
	always @(posedge clk or negedge arst_n) begin
		vertex_t nxt;
		if (!arst_n) begin
			vtx_valid <= 1'b0;
		end else begin
			if (vtx_valid && vertex_ch.ready) begin
				expected_pts.push_back(transform_vertex(vtx_x, vtx_y));
				vertex_cnt++;
			end
			if (!vtx_valid || vertex_ch.ready) begin
				if (pending_verts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_verts.pop_front();
					vtx_valid <= 1'b1;
					vtx_x <= nxt.x;
					vtx_y <= nxt.y;
				end else begin
					vtx_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random backpressure
	always @(posedge clk or negedge arst_n) begin
		point_t want;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (result_ch.valid && res_ready) begin
				if (expected_pts.size() == 0) begin
					$error("result beat with nothing outstanding: x_out %0d y_out %0d",
						result_ch.x_out, result_ch.y_out);
					mismatch_cnt++;
				end else begin
					want = expected_pts.pop_front();
					if (want.clipped)
						clipped_cnt++;
					if (result_ch.x_out !== want.x) begin
						$error("x_out: expected %0d, got %0d", want.x, result_ch.x_out);
						mismatch_cnt++;
					end
					if (result_ch.y_out !== want.y) begin
						$error("y_out: expected %0d, got %0d", want.y, result_ch.y_out);
						mismatch_cnt++;
					end
					if (result_ch.clipped !== want.clipped) begin
						$error("clipped: expected %0d, got %0d", want.clipped,
							result_ch.clipped);
						mismatch_cnt++;
					end
				end
			end
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// stimulus
	initial begin
		coef_shadow[REG_COEF_XX]  = COEF_ONE;
		coef_shadow[REG_COEF_XY]  = COEF_ZERO;
		coef_shadow[REG_COEF_YX]  = COEF_ZERO;
		coef_shadow[REG_COEF_YY]  = COEF_ONE;
		coef_shadow[REG_OFFSET_X] = COEF_ZERO;
		coef_shadow[REG_OFFSET_Y] = COEF_ZERO;

		wait (arst_n === 1'b1);
		@(posedge clk);

		// identity matrix straight out of reset
		queue_vertex(coord_t'(0), coord_t'(0));
		queue_vertex(COORD_MAX, COORD_MIN);
		queue_vertex(COORD_MIN, COORD_MAX);
		queue_vertex(coord_t'(-1), coord_t'(1));
		queue_vertex(coord_t'(12345), coord_t'(-23456));
		drain_pipe();

		// half-integer weights: ties must round toward plus infinity
		set_coef(REG_COEF_XX, COEF_HALF);
		set_coef(REG_COEF_YX, -COEF_HALF);
		set_coef(REG_OFFSET_X, COEF_HALF);
		set_coef(REG_COEF_XY, coef_t'(3 * COEF_HALF));
		set_coef(REG_COEF_YY, coef_t'(-3 * COEF_HALF));
		set_coef(REG_OFFSET_Y, -COEF_HALF);
		// writes past the register map change nothing
		reg_write(UNMAPPED_IDX, {DATA_W{1'b1}});
		reg_write(UNMAPPED_IDX + 1, DATA_W'(COEF_MAX));
		setting_cnt++;
		queue_vertex(coord_t'(1), coord_t'(1));
		queue_vertex(coord_t'(-1), coord_t'(-1));
		queue_vertex(coord_t'(3), coord_t'(-3));
		queue_vertex(coord_t'(-3), coord_t'(3));
		queue_vertex(coord_t'(1), coord_t'(0));
		queue_vertex(coord_t'(0), coord_t'(-1));
		queue_vertex(COORD_MAX, COORD_MIN);
		queue_vertex(COORD_MIN, COORD_MAX);
		drain_pipe();

		// extreme weights: saturation in both directions
		set_coef(REG_COEF_XX, COEF_MAX);
		set_coef(REG_COEF_YX, COEF_MIN);
		set_coef(REG_COEF_XY, COEF_MIN);
		set_coef(REG_COEF_YY, COEF_MAX);
		set_coef(REG_OFFSET_X, COEF_MAX);
		set_coef(REG_OFFSET_Y, COEF_MIN);
		setting_cnt++;
		queue_vertex(COORD_MAX, COORD_MAX);
		queue_vertex(COORD_MIN, COORD_MIN);
		queue_vertex(coord_t'(0), coord_t'(0));
		queue_vertex(coord_t'(1), coord_t'(-1));
		queue_vertex(coord_t'(-1), coord_t'(1));
		queue_vertex(COORD_MAX, COORD_MIN);
		drain_pipe();

		// random part: new matrix per setting, idle profile per group of settings
		for (int s = 0; s < NUM_SETTINGS; s++) begin
			if (s < 3) begin
				send_idle_pct = 20;
				recv_idle_pct = 61;
			end else if (s < 6) begin
				send_idle_pct = 61;
				recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int r = 0; r < NUM_REGS; r++) begin
				if (s == 0)
					set_coef(r, COEF_MAX);
				else if (s == 1)
					set_coef(r, COEF_MIN);
				else
					set_coef(r, rand_coef());
			end
			setting_cnt++;
			for (int n = 0; n < VERTS_PER_SETTING; n++)
				queue_vertex(rand_coord(), rand_coord());
			drain_pipe();
		end

		$display("covered %0d vertices under %0d register settings plus reset defaults",
			vertex_cnt, setting_cnt);
		$display("%0d results saturated, %0d field mismatches", clipped_cnt, mismatch_cnt);
		if (mismatch_cnt == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
